FILE: hw/rtl/rrfp_pkg.sv
// rrfp_pkg: shared constants and types for the rice residual fixed predictor decoder
// no dependencies
`default_nettype none

package rrfp_pkg;

  localparam int QUOTIENT_W  = 22;
  localparam int REMAINDER_W = 16;
  localparam int RICE_K_W    = 5;
  localparam int ORDER_W     = 2;

  typedef enum logic [ORDER_W-1:0] {
    ORDER_1 = 2'd0,
    ORDER_2 = 2'd1,
    ORDER_3 = 2'd2,
    ORDER_4 = 2'd3
  } order_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rrfp_fifo.sv
// rrfp_fifo: small register queue with count-based full and empty
// no dependencies
`default_nettype none

module rrfp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;
  logic             wr_en, rd_en;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign wr_en = push & ~full;
  assign rd_en = pop & ~empty;
  assign rdata = mem[rd_ptr];

  always_comb begin
    wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
    rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
    count_next  = count;
    if (wr_en && !rd_en) begin
      count_next = count + CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr_next;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr_next;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rrfp_front.sv
// rrfp_front: rice code to mapped value and signed residual fold
// depends on rrfp_pkg
`default_nettype none

module rrfp_front #(
  parameter int SAMPLE_BITS = 18,
  parameter int MAPPED_BITS = 24
) (
  input  wire logic [rrfp_pkg::QUOTIENT_W-1:0]  quotient,
  input  wire logic [rrfp_pkg::REMAINDER_W-1:0] remainder,
  input  wire logic [rrfp_pkg::RICE_K_W-1:0]    rice_k,
  output logic      [SAMPLE_BITS-1:0]           residual
);

  import rrfp_pkg::*;

  localparam int WIDE_W = MAPPED_BITS + SAMPLE_BITS;

  logic [MAPPED_BITS-1:0] q_ext;
  logic [MAPPED_BITS-1:0] r_ext;
  logic [MAPPED_BITS-1:0] mapped;
  logic [WIDE_W-1:0]      half_wide;
  logic [SAMPLE_BITS-1:0] half;

  // odd values fold to -(v+1)/2, which is the complement of v/2
  always_comb begin
    q_ext     = MAPPED_BITS'(quotient);
    r_ext     = MAPPED_BITS'(remainder);
    mapped    = (q_ext << rice_k) + r_ext;
    half_wide = WIDE_W'(mapped >> 1);
    half      = half_wide[SAMPLE_BITS-1:0];
    residual  = mapped[0] ? ~half : half;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rrfp_back.sv
// rrfp_back: fixed polynomial prediction, sample reconstruction and history
// depends on rrfp_pkg
`default_nettype none

module rrfp_back #(
  parameter int SAMPLE_BITS = 18
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_avail,
  input  wire logic [SAMPLE_BITS-1:0]       residual,
  input  wire logic [rrfp_pkg::ORDER_W-1:0] order_sel,
  output logic                              in_take,
  input  wire logic                         out_full,
  output logic                              out_push,
  output logic      [SAMPLE_BITS-1:0]       sample
);

  import rrfp_pkg::*;

  logic [SAMPLE_BITS-1:0] history [4];
  logic [SAMPLE_BITS-1:0] h0, h1, h2, h3;
  logic [SAMPLE_BITS-1:0] prediction;
  logic [SAMPLE_BITS-1:0] diff01;
  order_t                 order;

  assign in_take  = in_avail & ~out_full;
  assign out_push = in_take;

  always_comb begin
    h0     = history[0];
    h1     = history[1];
    h2     = history[2];
    h3     = history[3];
    order  = order_t'(order_sel);
    diff01 = h0 - h1;
    case (order)
      ORDER_1: prediction = h0;
      ORDER_2: prediction = (h0 << 1) - h1;
      ORDER_3: prediction = (diff01 << 1) + diff01 + h2;
      ORDER_4: prediction = ((h0 + h2) << 2) - (h1 << 2) - (h1 << 1) - h3;
      default: prediction = h0;
    endcase
    sample = residual + prediction;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history[0] <= '0;
      history[1] <= '0;
      history[2] <= '0;
      history[3] <= '0;
    end else if (in_take) begin
      history[0] <= sample;
      history[1] <= history[0];
      history[2] <= history[1];
      history[3] <= history[2];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rice_residual_fixed_predictor_decoder_unit.sv
// rice residual fixed predictor decoder: front fold, item queue, predictor back end
// depends on rrfp_pkg, rrfp_front, rrfp_fifo, rrfp_back
// path: an item is registered in the middle queue, its sample then in the output queue
// throughput: one item per cycle while the output queue is not full
// reset: synchronous; history cleared to zero, both two-entry queues emptied
`default_nettype none

module rice_residual_fixed_predictor_decoder_unit #(
  parameter int SAMPLE_BITS = 18,
  parameter int MAPPED_BITS = 24
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [rrfp_pkg::QUOTIENT_W-1:0]  quotient,
  input  wire logic [rrfp_pkg::REMAINDER_W-1:0] remainder,
  input  wire logic [rrfp_pkg::RICE_K_W-1:0]    rice_k,
  input  wire logic [rrfp_pkg::ORDER_W-1:0]     order_sel,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic signed [SAMPLE_BITS-1:0]         sample
);

  import rrfp_pkg::*;

  localparam int ITEM_W = SAMPLE_BITS + ORDER_W;

  logic [SAMPLE_BITS-1:0] residual;
  logic [ITEM_W-1:0]      mid_wdata, mid_rdata;
  logic                   mid_empty, mid_pop;
  logic                   out_full, out_push;
  logic [SAMPLE_BITS-1:0] back_sample;
  logic [SAMPLE_BITS-1:0] out_rdata;

  rrfp_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAPPED_BITS(MAPPED_BITS)
  ) u_front (
    .quotient (quotient),
    .remainder(remainder),
    .rice_k   (rice_k),
    .residual (residual)
  );

  assign mid_wdata = {order_sel, residual};

  rrfp_fifo #(
    .WIDTH(ITEM_W),
    .DEPTH(2)
  ) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(mid_wdata),
    .full (full),
    .pop  (mid_pop),
    .rdata(mid_rdata),
    .empty(mid_empty)
  );

  rrfp_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_avail (~mid_empty),
    .residual (mid_rdata[SAMPLE_BITS-1:0]),
    .order_sel(mid_rdata[ITEM_W-1:SAMPLE_BITS]),
    .in_take  (mid_pop),
    .out_full (out_full),
    .out_push (out_push),
    .sample   (back_sample)
  );

  rrfp_fifo #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(2)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (out_push),
    .wdata(back_sample),
    .full (out_full),
    .pop  (pop),
    .rdata(out_rdata),
    .empty(empty)
  );

  assign sample = $signed(out_rdata);

endmodule

`default_nettype wire

FILE: tb/tb.sv
// tb: self-checking bench for rice_residual_fixed_predictor_decoder_unit
// depends on rrfp_pkg and the decoder rtl; rice codes are decoded here and compared per sample
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrfp_pkg::*;

  localparam int SAMPLE_BITS = 18;
  localparam int MAPPED_BITS = 24;
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 80;

  typedef struct packed {
    logic [QUOTIENT_W-1:0]  q;
    logic [REMAINDER_W-1:0] r;
    logic [RICE_K_W-1:0]    k;
    order_t                 sel;
  } rice_code_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  logic [QUOTIENT_W-1:0]  quotient = '0;
  logic [REMAINDER_W-1:0] remainder = '0;
  logic [RICE_K_W-1:0]    rice_k = '0;
  logic [ORDER_W-1:0]     order_sel = '0;
  logic signed [SAMPLE_BITS-1:0] sample;

  rice_code_t codes_to_send[$];
  logic [SAMPLE_BITS-1:0] samples_due[$];
  logic [SAMPLE_BITS-1:0] recon_hist[4] = '{default: '0};

  int err_count = 0;
  int rx_count = 0;
  int gap_left = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  bit long_hold_done = 1'b0;
  bit no_idle = 1'b0;

  rice_residual_fixed_predictor_decoder_unit #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAPPED_BITS(MAPPED_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .quotient(quotient),
    .remainder(remainder),
    .rice_k(rice_k),
    .order_sel(order_sel),
    .empty(empty),
    .pop(pop),
    .sample(sample)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] decode_sample(input rice_code_t c);
    logic [63:0] wide;
    logic [63:0] mapped;
    logic [63:0] resid;
    logic [SAMPLE_BITS-1:0] h0, h1, h2, h3, pred;
    wide = (64'(c.q) << c.k) + 64'(c.r);
    mapped = wide & ((64'd1 << MAPPED_BITS) - 64'd1);
    if (!mapped[0]) resid = mapped >> 1;
    else resid = 64'd0 - ((mapped + 64'd1) >> 1);
    h0 = recon_hist[0];
    h1 = recon_hist[1];
    h2 = recon_hist[2];
    h3 = recon_hist[3];
    case (c.sel)
      ORDER_1: pred = h0;
      ORDER_2: pred = SAMPLE_BITS'(2 * h0 - h1);
      ORDER_3: pred = SAMPLE_BITS'(3 * h0 - 3 * h1 + h2);
      default: pred = SAMPLE_BITS'(4 * h0 - 6 * h1 + 4 * h2 - h3);
    endcase
    return resid[SAMPLE_BITS-1:0] + pred;
  endfunction

  // sender: one transaction per accepted code, expected sample formed at acceptance
  always @(posedge clk) begin
    rice_code_t c;
    logic [SAMPLE_BITS-1:0] s;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        c.q = quotient;
        c.r = remainder;
        c.k = rice_k;
        c.sel = order_t'(order_sel);
        s = decode_sample(c);
        samples_due = {samples_due, s};
        recon_hist[3] = recon_hist[2];
        recon_hist[2] = recon_hist[1];
        recon_hist[1] = recon_hist[0];
        recon_hist[0] = s;
      end
      if (!push || !full) begin
        if (gap_left > 0) begin
          push <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (codes_to_send.size() > 0) begin
          c = codes_to_send.pop_front();
          push <= 1'b1;
          quotient <= c.q;
          remainder <= c.r;
          rice_k <= c.k;
          order_sel <= c.sel;
          if (!no_idle && $urandom_range(0, 9) == 0) gap_left <= $urandom_range(1, 17);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result transaction against the oldest expected sample
  always @(posedge clk) begin
    logic [SAMPLE_BITS-1:0] want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        rx_count <= rx_count + 1;
        if (samples_due.size() == 0) begin
          report_mismatch($sformatf("unexpected sample %0d", sample));
        end else begin
          want = samples_due.pop_front();
          if ($unsigned(sample) !== want)
            report_mismatch($sformatf("sample %0d expected %0d", sample, $signed(want)));
        end
      end
      if (!long_hold_done && rx_count >= 300) begin
        long_hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 11) == 0) begin
        hold_left <= $urandom_range(0, 16);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_code(input int unsigned q, input int unsigned r, input int unsigned k,
                          input order_t sel);
    rice_code_t c;
    c.q = q[QUOTIENT_W-1:0];
    c.r = r[REMAINDER_W-1:0];
    c.k = k[RICE_K_W-1:0];
    c.sel = sel;
    codes_to_send = {codes_to_send, c};
  endtask

  task automatic add_random_codes(input int n);
    int unsigned k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        k = $urandom_range(0, 16);
        add_code(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 15),
                 $urandom & ((32'd1 << k) - 1), k, order_t'($urandom_range(0, 3)));
      end else begin
        add_code($urandom, $urandom, $urandom, order_t'($urandom_range(0, 3)));
      end
    end
  endtask

  task automatic wait_drained();
    while (codes_to_send.size() > 0 || push || samples_due.size() > 0) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    add_code(0, 0, 0, ORDER_1);
    add_code(1, 0, 0, ORDER_1);
    add_code(2, 0, 0, ORDER_2);
    add_code(3, 5, 2, ORDER_3);
    add_code(7, 1, 1, ORDER_4);
    add_code(9, 3, 2, ORDER_4);
    add_code(0, 16'hFFFF, 0, ORDER_2);
    add_code(22'h3FFFFF, 16'hFFFF, 16, ORDER_4);
    add_code(22'h3FFFFF, 0, 31, ORDER_3);
    add_code(1, 0, 23, ORDER_1);
    add_code(1, 1, 23, ORDER_2);
    add_code(22'h3FFFFF, 16'hFFFF, 2, ORDER_4);
    add_code(22'h1FFFFF, 16'hFFFE, 2, ORDER_4);
    add_code(5, 1, 17, ORDER_3);
    add_code(22'h2AAAAA, 16'h5555, 24, ORDER_1);
    add_code(22'h155555, 16'hAAAA, 8, ORDER_2);
    add_code(0, 16'hFFFF, 16, ORDER_4);
    add_code(0, 0, 0, ORDER_4);
    wait_drained();

    add_random_codes(1250);
    wait_drained();

    no_idle <= 1'b1;
    add_random_codes(600);
    wait_drained();
    repeat (10) @(posedge clk);

    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
